// File: sv/hsvrgb_pkg.sv
// hsvrgb_pkg: widths, constants, sector codes and stage word types
// shared by the hsv to rgb pipeline; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

   localparam int HUE_W  = 15;
   localparam int CH_W   = 8;
   localparam int RAMP_W = 12;
   localparam int NUM_W  = 20;
   localparam int PROD_W = 28;
   localparam int RCP_W  = 40;

   // one full turn of hue and one sixth of it, in 1/64 degree
   localparam logic [HUE_W-1:0]  HUE_FULL     = 15'd23040;
   localparam logic [RAMP_W-1:0] SECTOR_UNITS = 12'd3840;
   localparam logic [CH_W-1:0]   FULL_SCALE   = 8'd255;

   // mid = floor(v*t / (255*3840)) = floor((v*t >> 8) / 3825)
   localparam logic [NUM_W-1:0] DIV_CONST  = 20'd3825;
   localparam logic [RCP_W-1:0] DIV_RECIP  = 40'd1122867; // floor(2^32 / 3825)
   localparam int               DIV_SHIFT  = 32;

   // sector of the hue circle, named by largest then ramping channel
   typedef enum logic [2:0] {
      SEC_RG = 3'd0,
      SEC_GR = 3'd1,
      SEC_GB = 3'd2,
      SEC_BG = 3'd3,
      SEC_BR = 3'd4,
      SEC_RB = 3'd5
   } sector_type;

   // after hue decode: sector, ramp g, saturation, value
   typedef struct packed {
      sector_type          sector;
      logic [RAMP_W-1:0]   ramp;
      logic [CH_W-1:0]     sat;
      logic [CH_W-1:0]     top;
   } hue_info_type;

   // after chroma products: scaled mid numerator and finished low channel
   typedef struct packed {
      sector_type          sector;
      logic [NUM_W-1:0]    mid_num;
      logic [CH_W-1:0]     low;
      logic [CH_W-1:0]     top;
   } chroma_type;

   // all three levels ready for channel routing
   typedef struct packed {
      sector_type          sector;
      logic [CH_W-1:0]     mid;
      logic [CH_W-1:0]     low;
      logic [CH_W-1:0]     top;
   } level_type;

   function automatic logic [HUE_W-1:0] sector_base(input sector_type sector);
      logic [HUE_W-1:0] base;
      unique case (sector)
         SEC_RG:  base = 15'd0;
         SEC_GR:  base = 15'd3840;
         SEC_GB:  base = 15'd7680;
         SEC_BG:  base = 15'd11520;
         SEC_BR:  base = 15'd15360;
         SEC_RB:  base = 15'd19200;
         default: base = 15'd0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// File: sv/hsvrgb_req_if.sv
// hsvrgb_req_if: input word channel (valid, ready, hue, saturation, brightness)
// depends on hsvrgb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_req_if import hsvrgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CH_W-1:0]   saturation;
   logic [CH_W-1:0]   brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

// File: sv/hsvrgb_rsp_if.sv
// hsvrgb_rsp_if: result word channel (valid, ready, red, green, blue)
// depends on hsvrgb_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface hsvrgb_rsp_if import hsvrgb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  red;
   logic [CH_W-1:0]  green;
   logic [CH_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: sv/hsvrgb_hue_decode.sv
// hsvrgb_hue_decode: two stages, hue wrap and sector, then ramp g
// depends on hsvrgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_hue_decode import hsvrgb_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [HUE_W-1:0]  hue,
   input  logic [CH_W-1:0]   sat,
   input  logic [CH_W-1:0]   val,
   output hue_info_type      info
);

   logic [HUE_W-1:0]  hue_in, hue_ff;
   sector_type        sector_in, sector_ff;
   logic [CH_W-1:0]   sat_ff, val_ff;
   logic [HUE_W-1:0]  offset;
   logic [RAMP_W-1:0] frac;
   hue_info_type      info_in, info_ff;

   // stage a: wrap once, pick sector
   always_comb begin
      hue_in = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
      priority if (hue_in < 15'd3840)  sector_in = SEC_RG;
      else if (hue_in < 15'd7680)      sector_in = SEC_GR;
      else if (hue_in < 15'd11520)     sector_in = SEC_GB;
      else if (hue_in < 15'd15360)     sector_in = SEC_BG;
      else if (hue_in < 15'd19200)     sector_in = SEC_BR;
      else                             sector_in = SEC_RB;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hue_ff    <= hue_in;
         sector_ff <= sector_in;
         sat_ff    <= sat;
         val_ff    <= val;
      end
   end

   // stage b: odd sectors ramp down
   always_comb begin
      offset = hue_ff - sector_base(sector_ff);
      frac   = offset[RAMP_W-1:0];
      info_in.sector = sector_ff;
      info_in.ramp   = sector_ff[0] ? SECTOR_UNITS - frac : frac;
      info_in.sat    = sat_ff;
      info_in.top    = val_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

`default_nettype wire

// File: sv/hsvrgb_chroma.sv
// hsvrgb_chroma: two stages of products, mid numerator and low channel
// depends on hsvrgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_chroma import hsvrgb_pkg::*; (
   input  logic          clock,
   input  logic          enable,
   input  hue_info_type  info,
   output chroma_type    chroma
);

   logic [CH_W-1:0]    desat;
   logic [NUM_W-1:0]   t_in, t_ff;
   logic [2*CH_W-1:0]  lowprod_in, lowprod_ff;
   sector_type         sector_ff;
   logic [CH_W-1:0]    top_ff;
   logic [PROD_W-1:0]  full_num;
   logic [2*CH_W-1:0]  low_sum;
   chroma_type         chroma_in, chroma_ff;

   // stage c: t = 3840*(255-s) + s*g, and v*(255-s)
   always_comb begin
      desat      = FULL_SCALE - info.sat;
      t_in       = NUM_W'(desat) * NUM_W'(SECTOR_UNITS)
                 + NUM_W'(info.sat) * NUM_W'(info.ramp);
      lowprod_in = (2*CH_W)'(info.top) * (2*CH_W)'(desat);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff       <= t_in;
         lowprod_ff <= lowprod_in;
         sector_ff  <= info.sector;
         top_ff     <= info.top;
      end
   end

   // stage d: v*t pre-shifted by 256, and exact 16-bit divide by 255
   always_comb begin
      full_num = PROD_W'(top_ff) * PROD_W'(t_ff);
      low_sum  = lowprod_ff + {{CH_W{1'b0}}, lowprod_ff[2*CH_W-1:CH_W]} + 16'd1;
      chroma_in.sector  = sector_ff;
      chroma_in.mid_num = full_num[PROD_W-1:CH_W];
      chroma_in.low     = low_sum[2*CH_W-1:CH_W];
      chroma_in.top     = top_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         chroma_ff <= chroma_in;
      end
   end

   assign chroma = chroma_ff;

endmodule

`default_nettype wire

// File: sv/hsvrgb_mid_div.sv
// hsvrgb_mid_div: two-stage divide by 3825, reciprocal estimate then fix-up
// depends on hsvrgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_mid_div import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  chroma_type  chroma,
   output level_type   level
);

   logic [RCP_W-1:0]  recip_prod;
   logic [CH_W-1:0]   quot_in, quot_ff;
   chroma_type        chroma_ff;
   logic [NUM_W-1:0]  back_prod;
   logic [NUM_W-1:0]  remain;
   level_type         level_in, level_ff;

   // stage e: estimate, never high and at most one low
   always_comb begin
      recip_prod = RCP_W'(chroma.mid_num) * DIV_RECIP;
      quot_in    = recip_prod[DIV_SHIFT+CH_W-1:DIV_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff   <= quot_in;
         chroma_ff <= chroma;
      end
   end

   // stage f: remainder check
   always_comb begin
      back_prod       = NUM_W'(quot_ff) * DIV_CONST;
      remain          = chroma_ff.mid_num - back_prod;
      level_in.sector = chroma_ff.sector;
      level_in.mid    = (remain >= DIV_CONST) ? quot_ff + 8'd1 : quot_ff;
      level_in.low    = chroma_ff.low;
      level_in.top    = chroma_ff.top;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

// File: sv/hsv_to_rgb_convert.sv
// hsv_to_rgb_convert: top level of the six-sector hsv to rgb pipeline
// depends on hsvrgb_pkg, the channel interfaces and the three stage modules
//
// usage
//   req_port carries one pixel word: hue (1/64 degree), saturation, brightness
//   rsp_port returns one word per pixel: red, green, blue, in arrival order
//   hue of 23040 and up wraps once by a full turn
//   an accepted word passes all seven register stages to rsp valid when the sink keeps up
//   throughput: one word per cycle while the sink keeps up; the seven register stages move together
//   stages: wrap/sector, ramp, chroma products, v*t, reciprocal, fix-up, route
//   every stage carries a valid bit; empty slots are carried as bubbles
//   when the sink stalls with a word waiting, the whole pipe freezes and
//   req ready drops in the same cycle, so nothing is lost or repeated
//   a cycle with no word leaves a bubble that drains out as the pipe moves
//   synchronous reset clears every valid bit; no clearing pass, no memory
//   req ready is combinational from rsp ready through one gate
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_convert import hsvrgb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   hsvrgb_req_if.sink   req_port,
   hsvrgb_rsp_if.source rsp_port
);

   localparam int STAGES = 7;

   // valid bit per stage, stage STAGES is the output register
   logic [STAGES:1] valid_in, valid_ff;
   logic            advance;

   hue_info_type    info;
   chroma_type      chroma;
   level_type       level;

   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;

   // pipe moves when the output slot is empty or being taken
   assign advance        = !valid_ff[STAGES] || rsp_port.ready;
   assign req_port.ready = advance;

   always_comb begin
      valid_in = {valid_ff[STAGES-1:1], req_port.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stages 1-2: hue wrap, sector, ramp
   hsvrgb_hue_decode u_hue_decode (
      .clock  (clock),
      .enable (advance),
      .hue    (req_port.hue),
      .sat    (req_port.saturation),
      .val    (req_port.brightness),
      .info   (info)
   );

   // stages 3-4: products, low channel, mid numerator
   hsvrgb_chroma u_chroma (
      .clock  (clock),
      .enable (advance),
      .info   (info),
      .chroma (chroma)
   );

   // stages 5-6: mid channel by reciprocal divide
   hsvrgb_mid_div u_mid_div (
      .clock  (clock),
      .enable (advance),
      .chroma (chroma),
      .level  (level)
   );

   // stage 7: route top/mid/low onto r, g, b by sector
   always_comb begin
      unique case (level.sector)
         SEC_RG: begin
            red_in = level.top; green_in = level.mid; blue_in = level.low;
         end
         SEC_GR: begin
            red_in = level.mid; green_in = level.top; blue_in = level.low;
         end
         SEC_GB: begin
            red_in = level.low; green_in = level.top; blue_in = level.mid;
         end
         SEC_BG: begin
            red_in = level.low; green_in = level.mid; blue_in = level.top;
         end
         SEC_BR: begin
            red_in = level.mid; green_in = level.low; blue_in = level.top;
         end
         SEC_RB: begin
            red_in = level.top; green_in = level.low; blue_in = level.mid;
         end
         default: begin
            red_in = level.top; green_in = level.low; blue_in = level.mid;
         end
      endcase
   end

   // output register, payload held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_port.valid = valid_ff[STAGES];
   assign rsp_port.red   = red_ff;
   assign rsp_port.green = green_ff;
   assign rsp_port.blue  = blue_ff;

endmodule

`default_nettype wire

// File: sv/hsvrgb_checker.sv
// hsvrgb_checker: port-level assertions for hsv_to_rgb_convert, with bind
// depends on hsvrgb_pkg and the top level's channel ports
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_checker import hsvrgb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CH_W-1:0]   req_saturation,
   input logic [CH_W-1:0]   req_brightness,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CH_W-1:0]   rsp_red,
   input logic [CH_W-1:0]   rsp_green,
   input logic [CH_W-1:0]   rsp_blue
);

   logic gray_take;
   logic run_ok;

   assign gray_take = req_valid && req_ready && (req_saturation == 8'd0) && !reset;
   assign run_ok    = rsp_ready && !reset;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result word changed while stalled");

   // input side only stalls when the output slot is full and not taken
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req ready does not follow output slot");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // zero saturation gives gray at brightness, once the pixel has passed every stage with no stall
   a_gray_path: assert property (@(posedge clock) disable iff (reset)
      $past(gray_take, 7) && $past(run_ok, 6) && $past(run_ok, 5)
         && $past(run_ok, 4) && $past(run_ok, 3) && $past(run_ok, 2)
         && $past(run_ok, 1)
      |-> rsp_valid && (rsp_red == $past(req_brightness, 7))
         && (rsp_green == rsp_red) && (rsp_blue == rsp_red))
      else $error("gray pixel not delivered at expected latency");

endmodule

bind hsv_to_rgb_convert hsvrgb_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_saturation (req_port.saturation),
   .req_brightness (req_port.brightness),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_red        (rsp_port.red),
   .rsp_green      (rsp_port.green),
   .rsp_blue       (rsp_port.blue)
);

`default_nettype wire
